FILE: hw/rtl/hid_key_report_slot_table_top_defines.svh
// assertion macros for the key report slot table
`ifndef HID_KEY_REPORT_SLOT_TABLE_TOP_DEFINES_SVH
`define HID_KEY_REPORT_SLOT_TABLE_TOP_DEFINES_SVH

// property that must hold in the same cycle whenever the antecedent is true
`define HKST_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// property that must hold in the cycle after the antecedent is true
`define HKST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/hkst_pkg.sv
// shared types, constants and helpers of the key report slot table
package hkst_pkg;

    localparam int SLOTS        = 6;
    localparam int REPORT_SLOTS = 6;
    localparam int KEY_W        = 8;
    localparam int CNT_W        = 8;
    localparam int FUNC_W       = 2;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] COUNT_ONE = CNT_W'(1);

    // operation codes carried on the input tuser
    typedef enum logic [FUNC_W-1:0] {
        FUNC_PRESS   = 2'd0,
        FUNC_RELEASE = 2'd1,
        FUNC_CLEAR   = 2'd2
    } func_t;

    typedef logic [SLOTS-1:0][KEY_W-1:0] key_arr_t;
    typedef logic [SLOTS-1:0][CNT_W-1:0] cnt_arr_t;

    // one key event as seen by the update logic
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [KEY_W-1:0]  key;
        logic              enabled;
    } slot_op_t;

    // outcome of one key event
    typedef struct packed {
        key_arr_t keys;
        cnt_arr_t counts;
        logic     accepted;
    } slot_upd_t;

    // occupied slots form one run from slot 0
    function automatic logic slots_packed(input key_arr_t keys);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < SLOTS - 1; i++)
        begin
            if (keys[i] == '0 && keys[i+1] != '0)
            begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    // an empty slot always carries a zero count
    function automatic logic counts_consistent(input key_arr_t keys, input cnt_arr_t counts);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < SLOTS; i++)
        begin
            if ((keys[i] == '0) != (counts[i] == '0))
            begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

FILE: hw/rtl/hkst_slot_update.sv
// next table contents for one press, release or clear event
module hkst_slot_update (
    input  hkst_pkg::key_arr_t  keys,
    input  hkst_pkg::cnt_arr_t  counts,
    input  hkst_pkg::slot_op_t  op,
    output hkst_pkg::slot_upd_t upd
);

    logic [hkst_pkg::SLOTS-1:0] hit_first;
    logic [hkst_pkg::SLOTS-1:0] empty_first;
    logic [hkst_pkg::SLOTS-1:0] from_hit;
    logic                       hit_any;
    logic                       empty_any;
    logic [hkst_pkg::CNT_W-1:0] hit_count;
    logic                       key_ok;

    // first matching slot, first empty slot, and slots at or past the match
    always_comb
    begin
        logic seen_hit;
        logic seen_empty;
        seen_hit   = 1'b0;
        seen_empty = 1'b0;
        hit_count  = '0;
        for (int i = 0; i < hkst_pkg::SLOTS; i++)
        begin
            hit_first[i]   = (keys[i] == op.key) && !seen_hit;
            empty_first[i] = (keys[i] == '0) && !seen_empty;
            seen_hit       = seen_hit | (keys[i] == op.key);
            seen_empty     = seen_empty | (keys[i] == '0);
            from_hit[i]    = seen_hit;
            hit_count      = hit_count | (hit_first[i] ? counts[i] : '0);
        end
        hit_any   = seen_hit;
        empty_any = seen_empty;
    end

    assign key_ok = op.enabled && (op.key != '0);

    // table update per operation
    always_comb
    begin
        upd.keys     = keys;
        upd.counts   = counts;
        upd.accepted = 1'b0;
        case (op.func)
            hkst_pkg::FUNC_PRESS:
            begin
                if (key_ok && hit_any)
                begin
                    upd.accepted = 1'b1;
                    for (int i = 0; i < hkst_pkg::SLOTS; i++)
                    begin
                        if (hit_first[i] && counts[i] != hkst_pkg::COUNT_MAX)
                        begin
                            upd.counts[i] = counts[i] + hkst_pkg::COUNT_ONE;
                        end
                    end
                end
                else if (key_ok && empty_any)
                begin
                    upd.accepted = 1'b1;
                    for (int i = 0; i < hkst_pkg::SLOTS; i++)
                    begin
                        if (empty_first[i])
                        begin
                            upd.keys[i]   = op.key;
                            upd.counts[i] = hkst_pkg::COUNT_ONE;
                        end
                    end
                end
            end
            hkst_pkg::FUNC_RELEASE:
            begin
                if (key_ok && hit_any)
                begin
                    upd.accepted = 1'b1;
                    if (hit_count > hkst_pkg::COUNT_ONE)
                    begin
                        for (int i = 0; i < hkst_pkg::SLOTS; i++)
                        begin
                            if (hit_first[i])
                            begin
                                upd.counts[i] = hit_count - hkst_pkg::COUNT_ONE;
                            end
                        end
                    end
                    else
                    begin
                        // remove the slot, later slots move down one place
                        for (int i = 0; i < hkst_pkg::SLOTS - 1; i++)
                        begin
                            if (from_hit[i])
                            begin
                                upd.keys[i]   = keys[i+1];
                                upd.counts[i] = counts[i+1];
                            end
                        end
                        upd.keys[hkst_pkg::SLOTS-1]   = '0;
                        upd.counts[hkst_pkg::SLOTS-1] = '0;
                    end
                end
            end
            hkst_pkg::FUNC_CLEAR:
            begin
                upd.keys     = '0;
                upd.counts   = '0;
                upd.accepted = 1'b1;
            end
            default:
            begin
                upd.accepted = 1'b0;
            end
        endcase
    end

endmodule

FILE: hw/rtl/hid_key_report_slot_table_top.sv
// Keycode slot table of a boot-keyboard report with per-slot press counts.
//
// Input stream: s_tuser carries the operation (press, release, clear) and
// s_tdata the key's usage code. Each word updates the table in the cycle it
// is accepted and produces exactly one result word.
// Output stream: m_tuser says whether the operation took effect, m_tdata
// carries the six report slot keycodes after the update (0 = empty).
// Latency: the result is valid the cycle after the input word is accepted.
// Throughput: one word per cycle while results are taken; the table compare and
// shift are combinational and the table registers feed the next word directly.
// Stall: while a result waits on m_tready the input side is held off; the
// input is taken again in the same cycle the waiting result is taken.
// Configuration: cfg_we writes usb_enabled from cfg_wdata; write it only
// while no result is outstanding.
// Reset: all slots empty with zero counts, usb_enabled 0, no result pending.
module hid_key_report_slot_table_top (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic        cfg_wdata,    // usb_enabled
    // key event input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // [7:0] keycode
    input  logic [1:0]  s_tuser,      // [1:0] func
    // report output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,      // [7:0] slot_key_0 .. [47:40] slot_key_5
    output logic [0:0]  m_tuser       // [0] accepted
);

`include "hid_key_report_slot_table_top_defines.svh"

    logic                 usb_enabled_reg;
    hkst_pkg::key_arr_t   held_keys_reg;
    hkst_pkg::cnt_arr_t   hold_counts_reg;
    logic                 out_valid_reg;
    logic [47:0]          out_data_reg;
    logic [47:0]          out_data_next;
    logic                 out_acc_reg;
    hkst_pkg::slot_op_t   op;
    hkst_pkg::slot_upd_t  upd;
    logic                 in_fire;

    // input is taken when the result register is free or being drained
    assign s_tready = !out_valid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;

    assign op.func    = s_tuser;
    assign op.key     = s_tdata;
    assign op.enabled = usb_enabled_reg;

    hkst_slot_update u_update (
        .keys   (held_keys_reg),
        .counts (hold_counts_reg),
        .op     (op),
        .upd    (upd)
    );

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            usb_enabled_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            usb_enabled_reg <= cfg_wdata;
        end
    end

    // slot table state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_keys_reg   <= '0;
            hold_counts_reg <= '0;
        end
        else if (in_fire)
        begin
            held_keys_reg   <= upd.keys;
            hold_counts_reg <= upd.counts;
        end
    end

    // report packing, slot 0 in the low byte
    always_comb
    begin
        out_data_next = '0;
        for (int i = 0; i < hkst_pkg::REPORT_SLOTS; i++)
        begin
            if (i < hkst_pkg::SLOTS)
            begin
                out_data_next[i*hkst_pkg::KEY_W +: hkst_pkg::KEY_W] = upd.keys[i];
            end
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_data_reg <= out_data_next;
            out_acc_reg  <= upd.accepted;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_acc_reg;

    // table invariants and event effects
    `HKST_ASSERT_SAME(a_slots_packed, 1'b1, hkst_pkg::slots_packed(held_keys_reg),
        "occupied slots are not contiguous")
    `HKST_ASSERT_SAME(a_counts_match, 1'b1,
        hkst_pkg::counts_consistent(held_keys_reg, hold_counts_reg),
        "slot occupancy and count disagree")
    `HKST_ASSERT_NEXT(a_clear_empties, in_fire && s_tuser == hkst_pkg::FUNC_CLEAR,
        m_tuser[0] && m_tdata == '0 && hold_counts_reg == '0,
        "clear did not empty the table")
    `HKST_ASSERT_NEXT(a_reject_holds, in_fire && !upd.accepted,
        $stable(held_keys_reg) && $stable(hold_counts_reg) && !m_tuser[0],
        "rejected event changed the table")

endmodule

FILE: sim/tb_top.sv
// testbench of the key report slot table: directed rows, a held-key count-limit run, then random key sessions
module tb_top;

    localparam logic [hkst_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int KEY_EVENT_TARGET = 1650;
    localparam int STUCK_LIMIT      = 2000;
    localparam int LONG_STALL       = 300;
    localparam int SETTLE_CYCLES    = 4;
    localparam int NUM_DIRECTED     = 24;

    // one report word: accepted flag and the six slot keycodes
    typedef struct packed {
        logic                                                   accepted;
        logic [hkst_pkg::REPORT_SLOTS-1:0][hkst_pkg::KEY_W-1:0] slots;
    } key_report_t;

    // one directed row: usb enable wanted, operation, keycode, typed expectation
    typedef struct packed {
        logic                         usb_en;
        logic [hkst_pkg::FUNC_W-1:0]  op;
        logic [hkst_pkg::KEY_W-1:0]   key;
        logic                         typed;
        key_report_t                  want;
    } stim_row_t;

    localparam key_report_t EMPTY_REJECT = '0;
    localparam key_report_t EMPTY_OK     = {1'b1, 48'h0};

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;      // [7:0] keycode
    logic [1:0]  s_tuser;      // [1:0] func
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;      // [7:0] slot_key_0 .. [47:40] slot_key_5
    logic [0:0]  m_tuser;      // [0] accepted

    // predictor state
    logic                       usb_on;
    logic [hkst_pkg::KEY_W-1:0] slot_keys   [hkst_pkg::SLOTS];
    logic [hkst_pkg::CNT_W-1:0] slot_counts [hkst_pkg::SLOTS];

    key_report_t pending_reports [$];

    int mismatches          = 0;
    int reports_checked     = 0;
    int key_events          = 0;
    int full_rejects        = 0;
    int sat_presses         = 0;
    int usb_en_writes       = 0;
    int long_stall_requests = 0;
    int burst_left          = 0;
    int stuck_cycles        = 0;

    stim_row_t directed_rows [NUM_DIRECTED] = '{
        '{1'b0, hkst_pkg::FUNC_PRESS,   8'h04, 1'b1, EMPTY_REJECT},
        '{1'b0, hkst_pkg::FUNC_RELEASE, 8'h04, 1'b1, EMPTY_REJECT},
        '{1'b0, hkst_pkg::FUNC_CLEAR,   8'hFF, 1'b1, EMPTY_OK},
        '{1'b1, hkst_pkg::FUNC_PRESS,   8'h00, 1'b1, EMPTY_REJECT},
        '{1'b1, hkst_pkg::FUNC_PRESS,   8'hFF, 1'b1, {1'b1, 48'h0000_0000_00FF}},
        '{1'b1, hkst_pkg::FUNC_PRESS,   8'h01, 1'b1, {1'b1, 48'h0000_0000_01FF}},
        '{1'b1, hkst_pkg::FUNC_PRESS,   8'h80, 1'b0, EMPTY_REJECT},
        '{1'b1, hkst_pkg::FUNC_PRESS,   8'h55, 1'b0, EMPTY_REJECT},
        '{1'b1, hkst_pkg::FUNC_PRESS,   8'hAA, 1'b0, EMPTY_REJECT},
        '{1'b1, hkst_pkg::FUNC_PRESS,   8'h7F, 1'b0, EMPTY_REJECT},
        '{1'b1, hkst_pkg::FUNC_PRESS,   8'h02, 1'b0, EMPTY_REJECT},
        '{1'b1, hkst_pkg::FUNC_PRESS,   8'hFF, 1'b0, EMPTY_REJECT},
        '{1'b1, hkst_pkg::FUNC_RELEASE, 8'h7F, 1'b0, EMPTY_REJECT},
        '{1'b1, hkst_pkg::FUNC_RELEASE, 8'h01, 1'b0, EMPTY_REJECT},
        '{1'b1, hkst_pkg::FUNC_RELEASE, 8'hFF, 1'b0, EMPTY_REJECT},
        '{1'b1, hkst_pkg::FUNC_RELEASE, 8'hFF, 1'b0, EMPTY_REJECT},
        '{1'b1, hkst_pkg::FUNC_RELEASE, 8'h99, 1'b0, EMPTY_REJECT},
        '{1'b1, hkst_pkg::FUNC_RELEASE, 8'h00, 1'b0, EMPTY_REJECT},
        '{1'b1, FUNC_UNUSED,            8'h55, 1'b0, EMPTY_REJECT},
        '{1'b0, hkst_pkg::FUNC_PRESS,   8'h33, 1'b0, EMPTY_REJECT},
        '{1'b0, hkst_pkg::FUNC_RELEASE, 8'h80, 1'b0, EMPTY_REJECT},
        '{1'b0, hkst_pkg::FUNC_CLEAR,   8'h00, 1'b1, EMPTY_OK},
        '{1'b1, FUNC_UNUSED,            8'h00, 1'b1, EMPTY_REJECT},
        '{1'b1, hkst_pkg::FUNC_PRESS,   8'h02, 1'b0, EMPTY_REJECT}
    };

    hid_key_report_slot_table_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 clk = ~clk;

    // apply one key event to the predicted slot table and return the report
    function automatic key_report_t apply_key_event(input logic [hkst_pkg::FUNC_W-1:0] op,
                                                    input logic [hkst_pkg::KEY_W-1:0] key);
        key_report_t rpt;
        logic        ok;
        int          hit;
        int          j;
        ok  = 1'b0;
        hit = -1;
        if (op == hkst_pkg::FUNC_CLEAR)
        begin
            for (int i = 0; i < hkst_pkg::SLOTS; i++)
            begin
                slot_keys[i]   = '0;
                slot_counts[i] = '0;
            end
            ok = 1'b1;
        end
        else if ((op == hkst_pkg::FUNC_PRESS || op == hkst_pkg::FUNC_RELEASE) && usb_on
                 && key != '0)
        begin
            for (int i = 0; i < hkst_pkg::SLOTS; i++)
            begin
                if (hit < 0 && slot_keys[i] == key)
                begin
                    hit = i;
                end
            end
            if (op == hkst_pkg::FUNC_PRESS)
            begin
                if (hit >= 0)
                begin
                    // held key: count up, stuck at the top
                    if (slot_counts[hit] == hkst_pkg::COUNT_MAX)
                    begin
                        sat_presses++;
                    end
                    else
                    begin
                        slot_counts[hit] = slot_counts[hit] + 1'b1;
                    end
                    ok = 1'b1;
                end
                else
                begin
                    // new key takes the first empty slot
                    for (int i = 0; i < hkst_pkg::SLOTS; i++)
                    begin
                        if (hit < 0 && slot_keys[i] == '0)
                        begin
                            hit = i;
                        end
                    end
                    if (hit >= 0)
                    begin
                        slot_keys[hit]   = key;
                        slot_counts[hit] = hkst_pkg::COUNT_ONE;
                        ok = 1'b1;
                    end
                    else
                    begin
                        full_rejects++;
                    end
                end
            end
            else if (hit >= 0)
            begin
                if (slot_counts[hit] > hkst_pkg::COUNT_ONE)
                begin
                    slot_counts[hit] = slot_counts[hit] - 1'b1;
                end
                else
                begin
                    // remove and pull the occupied tail down one slot
                    j = hit;
                    while (j + 1 < hkst_pkg::SLOTS && slot_keys[j+1] != '0)
                    begin
                        slot_keys[j]   = slot_keys[j+1];
                        slot_counts[j] = slot_counts[j+1];
                        j++;
                    end
                    slot_keys[j]   = '0;
                    slot_counts[j] = '0;
                end
                ok = 1'b1;
            end
        end
        rpt = '0;
        rpt.accepted = ok;
        for (int i = 0; i < hkst_pkg::SLOTS && i < hkst_pkg::REPORT_SLOTS; i++)
        begin
            rpt.slots[i] = slot_keys[i];
        end
        return rpt;
    endfunction

    task automatic report_mismatch(input string what, input int field, input int want,
                                   input int got);
        $display("mismatch at %0t: %s field %0d want %0h got %0h", $realtime, what, field,
                 want, got);
        mismatches++;
    endtask

    // bursts of back-to-back words with random gaps between them
    task automatic pace_sender();
        int gap;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // offer one key event word and queue its report once it is taken
    task automatic send_key_event(input logic [hkst_pkg::FUNC_W-1:0] op,
                                  input logic [hkst_pkg::KEY_W-1:0] key,
                                  input logic typed, input key_report_t typed_want);
        key_report_t predicted;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= key;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        predicted = apply_key_event(op, key);
        pending_reports.push_back(typed ? typed_want : predicted);
        if (op != FUNC_UNUSED)
        begin
            key_events++;
        end
        pace_sender();
    endtask

    // stop offering and wait until every queued report has come back
    task automatic drain_reports();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_usb_enable(input logic value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        usb_on = value;
        usb_en_writes++;
        @(posedge clk);
    endtask

    // output receiver: own stall pattern plus long hold-offs on request
    initial
    begin
        int cycle;
        int mode;
        int served;
        int hold;
        cycle  = 0;
        mode   = 0;
        served = 0;
        hold   = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (served != long_stall_requests)
            begin
                served = long_stall_requests;
                hold   = LONG_STALL;
            end
            if (hold > 0)
            begin
                hold--;
                m_tready <= 1'b0;
            end
            else
            begin
                if (cycle % 64 == 0)
                begin
                    mode = $urandom_range(0, 3);
                end
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= (cycle % 4 == 0);
                    default: m_tready <= (cycle % 4 != 3);
                endcase
            end
            cycle++;
        end
    end

    // report checker: each word against the oldest queued report
    always @(posedge clk)
    begin
        key_report_t want;
        if (rst_n === 1'b1 && m_tvalid && m_tready)
        begin
            if (pending_reports.size() == 0)
            begin
                report_mismatch("unexpected report", 0, 0, m_tdata[7:0]);
            end
            else
            begin
                want = pending_reports.pop_front();
                if (m_tuser[0] !== want.accepted)
                begin
                    report_mismatch("accepted", 0, want.accepted, m_tuser[0]);
                end
                for (int i = 0; i < hkst_pkg::REPORT_SLOTS; i++)
                begin
                    if (m_tdata[i*hkst_pkg::KEY_W +: hkst_pkg::KEY_W] !== want.slots[i])
                    begin
                        report_mismatch("slot key", i, want.slots[i],
                                        m_tdata[i*hkst_pkg::KEY_W +: hkst_pkg::KEY_W]);
                    end
                end
            end
            reports_checked++;
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            stuck_cycles = 0;
        end
        else
        begin
            stuck_cycles++;
        end
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        int                          kind;
        int                          n_pool;
        int                          reps;
        logic [hkst_pkg::KEY_W-1:0]  pool [9];
        logic [hkst_pkg::FUNC_W-1:0] op;
        logic [hkst_pkg::KEY_W-1:0]  key;
        bit                          stall_done;
        bit                          pause_done;
        stall_done = 1'b0;
        pause_done = 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= 1'b0;
        rst_n     <= 1'b0;
        usb_on = 1'b0;
        for (int i = 0; i < hkst_pkg::SLOTS; i++)
        begin
            slot_keys[i]   = '0;
            slot_counts[i] = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed rows, switching usb enable only while idle
        foreach (directed_rows[r])
        begin
            if (directed_rows[r].usb_en != usb_on)
            begin
                drain_reports();
                write_usb_enable(directed_rows[r].usb_en);
            end
            send_key_event(directed_rows[r].op, directed_rows[r].key, directed_rows[r].typed,
                           directed_rows[r].want);
        end

        // hold one key past the count limit, then back off a little
        key = 8'($urandom_range(1, 255));
        send_key_event(hkst_pkg::FUNC_CLEAR, 8'($urandom_range(0, 255)), 1'b0, '0);
        reps = $urandom_range(256, 262);
        repeat (reps) send_key_event(hkst_pkg::FUNC_PRESS, key, 1'b0, '0);
        repeat (3) send_key_event(hkst_pkg::FUNC_RELEASE, key, 1'b0, '0);

        // random part: mostly key sessions over a small pool of keys
        while (key_events < KEY_EVENT_TARGET)
        begin
            if (!stall_done && key_events >= 600)
            begin
                stall_done = 1'b1;
                long_stall_requests++;
            end
            if (!pause_done && key_events >= 1100)
            begin
                pause_done = 1'b1;
                drain_reports();
            end
            kind = $urandom_range(0, 99);
            if (kind < 65)
            begin
                n_pool = $urandom_range(2, 9);
                for (int i = 0; i < n_pool; i++)
                begin
                    pool[i] = 8'($urandom_range(1, 255));
                end
                repeat ($urandom_range(6, 30))
                begin
                    op  = ($urandom_range(0, 99) < 55) ? hkst_pkg::FUNC_PRESS
                                                       : hkst_pkg::FUNC_RELEASE;
                    key = ($urandom_range(0, 19) == 0) ? '0 : pool[$urandom_range(0, n_pool - 1)];
                    send_key_event(op, key, 1'b0, '0);
                end
            end
            else if (kind < 80)
            begin
                // noise: any operation code with any keycode
                repeat ($urandom_range(1, 8))
                begin
                    send_key_event(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                                   1'b0, '0);
                end
            end
            else if (kind < 88)
            begin
                send_key_event(hkst_pkg::FUNC_CLEAR, 8'($urandom_range(0, 255)), 1'b0, '0);
            end
            else if (kind < 94)
            begin
                drain_reports();
                write_usb_enable(usb_on ? 1'($urandom_range(0, 2) != 0) : 1'b1);
            end
            else
            begin
                // repeated presses of one key, then the matching releases
                key  = 8'($urandom_range(1, 255));
                reps = $urandom_range(2, 10);
                repeat (reps) send_key_event(hkst_pkg::FUNC_PRESS, key, 1'b0, '0);
                repeat (reps + $urandom_range(0, 1))
                    send_key_event(hkst_pkg::FUNC_RELEASE, key, 1'b0, '0);
            end
        end

        drain_reports();
        if (pending_reports.size() != 0)
        begin
            report_mismatch("reports never arrived", 0, pending_reports.size(), 0);
        end
        $display("covered %0d key events and %0d report words, %0d table-full rejects",
                 key_events, reports_checked, full_rejects);
        $display("%0d presses at the count limit, %0d usb enable writes, %0d long stalls",
                 sat_presses, usb_en_writes, long_stall_requests);
        if (mismatches == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/hkst_pkg.sv
hw/rtl/hkst_slot_update.sv
hw/rtl/hid_key_report_slot_table_top.sv
sim/tb_top.sv
